// File: hw/rtl/gcs_pkg.sv
// Shared constants, request and register codes, and job/result types of the
// streaming Gaussian convolution block. No dependencies.
package gcs_pkg;

  localparam int GCS_MAX_WIDTH      = 1024;
  localparam int GCS_MAX_MASK       = 19;
  localparam int GCS_PIXEL_BITS     = 16;
  localparam int GCS_COEF_FRAC_BITS = 16;

  localparam int REQ_W      = 2;
  localparam int CIDX_W     = 9;
  localparam int COEF_W     = 17;
  localparam int PIX_PORT_W = 16;
  localparam int OCOL_W     = 10;
  localparam int ROW_W      = 12;
  localparam int COL_FW     = 12;
  localparam int MASK_W     = 5;
  localparam int DIM_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [REQ_W-1:0] REQ_COEF  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_FW-1:0] col;
    logic [MASK_W-1:0] row0;
    logic [COL_FW-1:0] col0;
    logic [MASK_W-1:0] m;
    logic              border;
    logic              last;
  } gcs_job_t;

  typedef struct packed {
    logic [PIX_PORT_W-1:0] value;
    logic [ROW_W-1:0]      row;
    logic [COL_FW-1:0]     col;
    logic                  border;
    logic                  last;
  } gcs_res_t;

endpackage

// File: hw/rtl/gcs_if.sv
// Valid/ready stream interfaces for request beats and result beats.
// Depends on gcs_pkg.
interface gcs_in_if import gcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CIDX_W-1:0] coef_index;
  logic [COEF_W-1:0] coef_value;
  logic [PIX_PORT_W-1:0] pixel;
  modport source (output valid, req_type, coef_index, coef_value, pixel, input ready);
  modport sink (input valid, req_type, coef_index, coef_value, pixel, output ready);
endinterface

interface gcs_out_if import gcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] value;
  logic [OCOL_W-1:0]     out_col;
  logic [ROW_W-1:0]      out_row;
  logic                  is_border;
  logic                  last_of_frame;
  modport source (output valid, value, out_col, out_row, is_border, last_of_frame,
                  input ready);
  modport sink (input valid, value, out_col, out_row, is_border, last_of_frame,
                output ready);
endinterface

// File: hw/rtl/gcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/gcs_window.sv
// Window engine: coefficient and line memories plus one serial multiply-
// accumulate pass over the mask. Depends on gcs_pkg and gcs_ram.
module gcs_window import gcs_pkg::*; #(
  parameter int MAX_WIDTH      = GCS_MAX_WIDTH,
  parameter int MAX_MASK       = GCS_MAX_MASK,
  parameter int PIXEL_BITS     = GCS_PIXEL_BITS,
  parameter int COEF_FRAC_BITS = GCS_COEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  gcs_job_t job,
  output logic eng_idle,
  input  logic lwr_en,
  input  logic [$clog2(MAX_MASK*MAX_WIDTH)-1:0] lwr_addr,
  input  logic [PIXEL_BITS-1:0] lwr_data,
  input  logic cwr_en,
  input  logic [$clog2(MAX_MASK*MAX_MASK)-1:0] cwr_addr,
  input  logic [COEF_W-1:0] cwr_data,
  output logic res_valid,
  output gcs_res_t res,
  input  logic res_take
);

  localparam int LA_W   = $clog2(MAX_MASK*MAX_WIDTH);
  localparam int CA_W   = $clog2(MAX_MASK*MAX_MASK);
  localparam int RM_W   = $clog2(MAX_MASK);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int PROD_W = COEF_W + PIXEL_BITS;
  localparam int ACC_W  = PROD_W + CA_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state_r, state_nxt;
  gcs_job_t job_r;
  logic [MASK_W-1:0] a_r, b_r;
  logic [RM_W-1:0] rm_r;
  logic [COL_W-1:0] col_r;
  logic [CA_W-1:0] ci_r;
  logic d_v_r, d_last_r, p_v_r, p_last_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0] acc_r, sum;
  logic [ACC_W-1:0] shifted;
  logic [PIXEL_BITS-1:0] val_r, sat_val;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [COEF_W-1:0] coef_q;
  logic [LA_W-1:0] line_raddr;
  logic issue_last;

  assign line_raddr = LA_W'(rm_r) * LA_W'(MAX_WIDTH) + LA_W'(col_r);
  assign issue_last = job_r.border ||
                      ((a_r == job_r.m - 5'd1) && (b_r == job_r.m - 5'd1));

  gcs_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_MASK*MAX_WIDTH)) u_line (
    .clk(clk), .we(lwr_en), .waddr(lwr_addr), .wdata(lwr_data),
    .raddr(line_raddr), .rdata(pix_q)
  );

  gcs_ram #(.WIDTH(COEF_W), .DEPTH(MAX_MASK*MAX_MASK)) u_coef (
    .clk(clk), .we(cwr_en), .waddr(cwr_addr), .wdata(cwr_data),
    .raddr(ci_r), .rdata(coef_q)
  );

  assign sum     = acc_r + ACC_W'(prod_r);
  assign shifted = sum >> COEF_FRAC_BITS;
  assign sat_val = (shifted > ACC_W'({PIXEL_BITS{1'b1}})) ? {PIXEL_BITS{1'b1}}
                                                           : shifted[PIXEL_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_RUN;
      ST_RUN:   if (issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if ((d_v_r && d_last_r && job_r.border) || (p_v_r && p_last_r)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD:  if (res_take) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d_v_r   <= 1'b0;
      p_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      d_v_r   <= (state_r == ST_RUN);
      p_v_r   <= d_v_r && !job_r.border;
    end
  end

  always_ff @(posedge clk) begin
    d_last_r <= (state_r == ST_RUN) && issue_last;
    p_last_r <= d_last_r;
    if (state_r == ST_IDLE && start) begin
      job_r <= job;
      a_r   <= '0;
      b_r   <= '0;
      ci_r  <= '0;
      rm_r  <= RM_W'(job.row0);
      col_r <= COL_W'(job.col0);
      acc_r <= '0;
    end else if (state_r == ST_RUN && !issue_last) begin
      ci_r <= ci_r + 1'b1;
      if (a_r == job_r.m - 5'd1) begin
        a_r   <= '0;
        b_r   <= b_r + 5'd1;
        col_r <= COL_W'(job_r.col0);
        rm_r  <= (rm_r == RM_W'(MAX_MASK - 1)) ? '0 : rm_r + 1'b1;
      end else begin
        a_r   <= a_r + 5'd1;
        col_r <= col_r + 1'b1;
      end
    end
    if (d_v_r) begin
      if (job_r.border) begin
        val_r <= pix_q;
      end else begin
        prod_r <= PROD_W'(coef_q) * PROD_W'(pix_q);
      end
    end
    if (p_v_r) begin
      acc_r <= sum;
      if (p_last_r) begin
        val_r <= sat_val;
      end
    end
  end

  assign eng_idle   = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_HOLD);
  assign res.value  = PIX_PORT_W'(val_r);
  assign res.row    = job_r.row;
  assign res.col    = job_r.col;
  assign res.border = job_r.border;
  assign res.last   = job_r.last;

endmodule

// File: hw/rtl/gaussian_conv2d_stream_unit.sv
// Top level of the streaming 2D Gaussian convolution block: configuration
// registers, raster counters, result scheduling and the output register.
// Depends on gcs_pkg, gcs_if and gcs_window.
//
// Pixels enter in raster order and are stored in a line memory of MAX_MASK
// rows; coefficients are stored in a separate memory. A coefficient write,
// an ignored beat or a pixel that releases no result leaves the engine
// idle. A result that lies on the border is read back from the line
// memory. A filtered result runs one multiplier over the mask one
// coefficient per cycle. Input is taken again once the result has
// moved into the output register, which holds it until taken.
// After reset the memories are undefined: all coefficients in use must be
// written before the first filtered result.
module gaussian_conv2d_stream_unit import gcs_pkg::*; #(
  parameter int MAX_WIDTH      = GCS_MAX_WIDTH,
  parameter int MAX_MASK       = GCS_MAX_MASK,
  parameter int PIXEL_BITS     = GCS_PIXEL_BITS,
  parameter int COEF_FRAC_BITS = GCS_COEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gcs_in_if.sink                in_bus,
  gcs_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LA_W  = $clog2(MAX_MASK*MAX_WIDTH);
  localparam int CA_W  = $clog2(MAX_MASK*MAX_MASK);
  localparam int RM_W  = $clog2(MAX_MASK);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LIN_W = ROW_W + COL_W + 1;

  logic [10:0] cfg_w_r;
  logic [DIM_W-1:0] cfg_h_r;
  logic [MASK_W-1:0] cfg_m_r;

  logic [DIM_W-1:0] w_eff, h_eff, wz, hz;
  logic [MASK_W-1:0] m_eff, mc, half;
  logic [LIN_W-1:0] lag;

  logic [COL_W-1:0] in_col_r, in_col_nxt, res_col_r, res_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, res_row_r, res_row_nxt;
  logic [RM_W-1:0] in_rm_r, in_rm_nxt, res_rm_r, res_rm_nxt;
  logic [LIN_W-1:0] n_r, n_nxt, q_r, q_nxt;
  logic in_full_r, in_full_nxt;

  logic in_fire, emit, lwr_en, cwr_en, eng_idle, eng_res_valid, eng_take;
  logic cfg_restart;
  logic [LA_W-1:0] lwr_addr;
  gcs_job_t job;
  gcs_res_t eng_res, out_res_r;
  logic out_valid_r;
  logic [DIM_W:0] rc, rr;

  always_comb begin
    wz    = (cfg_w_r == '0) ? DIM_W'(1) : DIM_W'(cfg_w_r);
    w_eff = (wz > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : wz;
    hz    = (cfg_h_r == '0) ? DIM_W'(1) : cfg_h_r;
    h_eff = (hz > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : hz;
    mc    = (cfg_m_r > MASK_W'(MAX_MASK)) ? MASK_W'(MAX_MASK) : cfg_m_r;
    if (mc[0]) begin
      m_eff = mc;
    end else begin
      m_eff = (mc == '0) ? MASK_W'(1) : mc - MASK_W'(1);
    end
    half = (m_eff - MASK_W'(1)) >> 1;
    lag  = LIN_W'(half) * LIN_W'(w_eff) + LIN_W'(half);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 11'd1024;
      cfg_h_r <= 13'd1024;
      cfg_m_r <= 5'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_w_r <= cfg_data[10:0];
        CFG_HEIGHT: cfg_h_r <= cfg_data;
        CFG_MASK:   cfg_m_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_restart  = cfg_we && (cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_MASK});
  assign in_bus.ready = eng_idle && !cfg_we;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign lwr_addr     = LA_W'(in_rm_r) * LA_W'(MAX_WIDTH) + LA_W'(in_col_r);

  assign rc = (DIM_W+1)'(res_col_r);
  assign rr = (DIM_W+1)'(res_row_r);

  always_comb begin
    job.row    = res_row_r;
    job.col    = COL_FW'(res_col_r);
    job.m      = m_eff;
    job.border = (rc < (DIM_W+1)'(half)) || (rc + (DIM_W+1)'(half) >= (DIM_W+1)'(w_eff)) ||
                 (rr < (DIM_W+1)'(half)) || (rr + (DIM_W+1)'(half) >= (DIM_W+1)'(h_eff));
    job.last   = (rr + 1'b1 == (DIM_W+1)'(h_eff)) && (rc + 1'b1 == (DIM_W+1)'(w_eff));
    if (job.border) begin
      job.row0 = MASK_W'(res_rm_r);
      job.col0 = COL_FW'(res_col_r);
    end else begin
      job.row0 = (MASK_W'(res_rm_r) >= half) ? MASK_W'(res_rm_r) - half
                                            : MASK_W'(res_rm_r) + MASK_W'(MAX_MASK) - half;
      job.col0 = COL_FW'(res_col_r) - COL_FW'(half);
    end
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    in_rm_nxt   = in_rm_r;
    n_nxt       = n_r;
    in_full_nxt = in_full_r;
    res_col_nxt = res_col_r;
    res_row_nxt = res_row_r;
    res_rm_nxt  = res_rm_r;
    q_nxt       = q_r;
    lwr_en      = 1'b0;
    cwr_en      = 1'b0;
    emit        = 1'b0;
    if (in_fire) begin
      case (in_bus.req_type)
        REQ_COEF:  cwr_en = (in_bus.coef_index < CIDX_W'(MAX_MASK*MAX_MASK));
        REQ_FLUSH: emit = in_full_r;
        REQ_PIXEL: begin
          if (!in_full_r) begin
            lwr_en = 1'b1;
            n_nxt  = n_r + 1'b1;
            if (DIM_W'(in_col_r) + 1'b1 >= w_eff) begin
              in_col_nxt = '0;
              in_rm_nxt  = (in_rm_r == RM_W'(MAX_MASK - 1)) ? '0 : in_rm_r + 1'b1;
              if (DIM_W'(in_row_r) + 1'b1 >= h_eff) begin
                in_row_nxt  = '0;
                in_rm_nxt   = '0;
                in_full_nxt = 1'b1;
              end else begin
                in_row_nxt = in_row_r + 1'b1;
              end
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
            emit = in_full_nxt || (q_r + lag <= n_r);
          end
        end
        default: ;
      endcase
      if (emit) begin
        q_nxt = q_r + 1'b1;
        if (rc + 1'b1 >= (DIM_W+1)'(w_eff)) begin
          res_col_nxt = '0;
          res_row_nxt = res_row_r + 1'b1;
          res_rm_nxt  = (res_rm_r == RM_W'(MAX_MASK - 1)) ? '0 : res_rm_r + 1'b1;
        end else begin
          res_col_nxt = res_col_r + 1'b1;
        end
      end
    end
    if (cfg_restart || (emit && job.last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_rm_nxt   = '0;
      n_nxt       = '0;
      in_full_nxt = 1'b0;
      res_col_nxt = '0;
      res_row_nxt = '0;
      res_rm_nxt  = '0;
      q_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_rm_r   <= '0;
      n_r       <= '0;
      in_full_r <= 1'b0;
      res_col_r <= '0;
      res_row_r <= '0;
      res_rm_r  <= '0;
      q_r       <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      in_rm_r   <= in_rm_nxt;
      n_r       <= n_nxt;
      in_full_r <= in_full_nxt;
      res_col_r <= res_col_nxt;
      res_row_r <= res_row_nxt;
      res_rm_r  <= res_rm_nxt;
      q_r       <= q_nxt;
    end
  end

  gcs_window #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_MASK(MAX_MASK),
    .PIXEL_BITS(PIXEL_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_window (
    .clk(clk), .rst_n(rst_n), .start(emit), .job(job), .eng_idle(eng_idle),
    .lwr_en(lwr_en), .lwr_addr(lwr_addr), .lwr_data(in_bus.pixel[PIXEL_BITS-1:0]),
    .cwr_en(cwr_en), .cwr_addr(in_bus.coef_index[CA_W-1:0]),
    .cwr_data(in_bus.coef_value),
    .res_valid(eng_res_valid), .res(eng_res), .res_take(eng_take)
  );

  assign eng_take = eng_res_valid && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_take) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.value         = out_res_r.value;
  assign out_bus.out_col       = OCOL_W'(out_res_r.col);
  assign out_bus.out_row       = out_res_r.row;
  assign out_bus.is_border     = out_res_r.border;
  assign out_bus.last_of_frame = out_res_r.last;

  a_full_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r |-> (in_col_r == '0 && in_row_r == '0))
    else $error("Input counters not cleared after the last pixel of a frame.");

  a_res_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(res_col_r) < w_eff)
    else $error("Result column outside the frame width.");

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(in_col_r) < w_eff)
    else $error("Input column outside the frame width.");

  a_res_behind_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full_r |-> (q_r <= n_r))
    else $error("A result was scheduled ahead of its input pixels.");

endmodule

// File: bench/gcs_conv_checker.sv
// Checker for the streaming Gaussian convolution block: watches the request,
// result and register ports, predicts every result pixel and compares it.
// Depends on gcs_pkg and gcs_if.
`timescale 1ns / 1ps

module gcs_conv_checker import gcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gcs_in_if                     in_mon,
  gcs_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output logic                  frame_open
);

  typedef struct packed {
    logic [PIX_PORT_W-1:0] value;
    logic [OCOL_W-1:0]     col;
    logic [ROW_W-1:0]      row;
    logic                  border;
    logic                  last;
  } smooth_pix_t;

  localparam int unsigned COEF_DEPTH = GCS_MAX_MASK * GCS_MAX_MASK;

  smooth_pix_t expected_pix_q[$];
  logic [COEF_W-1:0]     coef_mem [0:COEF_DEPTH-1];
  logic [PIX_PORT_W-1:0] line_mem [0:GCS_MAX_MASK-1][0:GCS_MAX_WIDTH-1];
  logic [10:0]           width_reg;
  logic [12:0]           height_reg;
  logic [4:0]            mask_reg;
  int unsigned           in_c, in_r, res_c, res_r;
  bit                    in_full;
  int                    mismatch_count;

  assign errors = mismatch_count;

  initial mismatch_count = 0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > GCS_MAX_WIDTH) w = GCS_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned eff_mask();
    int unsigned m;
    m = mask_reg;
    if (m > GCS_MAX_MASK) m = GCS_MAX_MASK;
    if (m % 2 == 0) m = (m == 0) ? 1 : m - 1;
    return m;
  endfunction

  task automatic restart_frame();
    in_c = 0;
    in_r = 0;
    res_c = 0;
    res_r = 0;
    in_full = 0;
    expected_pix_q.delete();
  endtask

  task automatic predict_smoothed();
    int unsigned w, h, m, half, r, c, a, b;
    longint unsigned acc;
    smooth_pix_t p;
    w = eff_width();
    h = eff_height();
    m = eff_mask();
    half = (m - 1) / 2;
    r = res_r;
    c = res_c;
    p.border = (c < half) || (c + half >= w) || (r < half) || (r + half >= h);
    p.last = (r + 1 == h) && (c + 1 == w);
    if (p.border) begin
      p.value = line_mem[r % GCS_MAX_MASK][c];
    end else begin
      acc = 0;
      for (b = 0; b < m; b++) begin
        for (a = 0; a < m; a++) begin
          acc += longint'(coef_mem[a + b * m]) *
                 longint'(line_mem[(r + b - half) % GCS_MAX_MASK][c + a - half]);
        end
      end
      acc = acc >> GCS_COEF_FRAC_BITS;
      p.value = (acc > 65535) ? 16'hFFFF : acc[15:0];
    end
    p.col = c[OCOL_W-1:0];
    p.row = r[ROW_W-1:0];
    expected_pix_q.push_back(p);
    if (p.last) begin
      in_c = 0;
      in_r = 0;
      res_c = 0;
      res_r = 0;
      in_full = 0;
    end else if (c + 1 >= w) begin
      res_c = 0;
      res_r = r + 1;
    end else begin
      res_c = c + 1;
    end
  endtask

  task automatic take_pixel(input logic [PIX_PORT_W-1:0] pix);
    int unsigned w, h, m, half, n, lag, q;
    w = eff_width();
    h = eff_height();
    m = eff_mask();
    half = (m - 1) / 2;
    n = in_r * w + in_c;
    lag = half * w + half;
    line_mem[in_r % GCS_MAX_MASK][in_c] = pix;
    if (in_c + 1 >= w) begin
      in_c = 0;
      if (in_r + 1 >= h) begin
        in_r = 0;
        in_full = 1;
      end else begin
        in_r++;
      end
    end else begin
      in_c++;
    end
    q = res_r * w + res_c;
    if (in_full || q + lag <= n) predict_smoothed();
  endtask

  always @(posedge clk) begin
    smooth_pix_t exp_pix, got_pix;
    if (!rst_n) begin
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      mask_reg = 5'd3;
      restart_frame();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg = cfg_data[10:0];
          CFG_HEIGHT: height_reg = cfg_data[12:0];
          CFG_MASK:   mask_reg = cfg_data[4:0];
          default: ;
        endcase
        if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT || cfg_index == CFG_MASK)
          restart_frame();
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.req_type)
          REQ_COEF: begin
            if (in_mon.coef_index < COEF_DEPTH) coef_mem[in_mon.coef_index] = in_mon.coef_value;
          end
          REQ_PIXEL: begin
            if (!in_full) take_pixel(in_mon.pixel);
          end
          REQ_FLUSH: begin
            if (in_full) predict_smoothed();
          end
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got_pix = '{out_mon.value, out_mon.out_col, out_mon.out_row,
                    out_mon.is_border, out_mon.last_of_frame};
        if (expected_pix_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected result beat value=%0d col=%0d row=%0d border=%0b last=%0b",
                     got_pix.value, got_pix.col, got_pix.row, got_pix.border, got_pix.last);
        end else begin
          exp_pix = expected_pix_q.pop_front();
          if (got_pix !== exp_pix) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: result beat expected value=%0d col=%0d row=%0d border=%0b last=%0b, got value=%0d col=%0d row=%0d border=%0b last=%0b",
                       exp_pix.value, exp_pix.col, exp_pix.row, exp_pix.border, exp_pix.last,
                       got_pix.value, got_pix.col, got_pix.row, got_pix.border, got_pix.last);
          end
        end
      end
    end
    pending <= expected_pix_q.size();
    frame_open <= in_full;
  end

endmodule

// File: bench/gaussian_conv2d_stream_unit_tb.sv
// Top of the Gaussian convolution testbench: clock, reset, stimulus of
// register writes, coefficient loads and frames, and the final verdict.
// Depends on gcs_pkg, gcs_if, gcs_conv_checker and gaussian_conv2d_stream_unit.
`timescale 1ns / 1ps

module gaussian_conv2d_stream_unit_tb;
  import gcs_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending;
  logic frame_open;
  int stall_cycles;
  bit no_idle;
  int pixels_sent;
  int cur_mask;

  gcs_in_if in_bus();
  gcs_out_if out_bus();

  gaussian_conv2d_stream_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gcs_conv_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .frame_open(frame_open)
  );

  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n;
    out_bus.ready <= 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_bus.ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_bus.ready <= 1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  task automatic send_beat(input logic [REQ_W-1:0] kind, input int unsigned idx,
                           input int unsigned coef, input int unsigned pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.req_type <= kind;
    in_bus.coef_index <= idx[CIDX_W-1:0];
    in_bus.coef_value <= coef[COEF_W-1:0];
    in_bus.pixel <= pix[PIX_PORT_W-1:0];
    in_bus.valid <= 1;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned m);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_MASK, m);
    cur_mask = (m > 19) ? 19 : m;
    if (cur_mask % 2 == 0) cur_mask = (cur_mask == 0) ? 1 : cur_mask - 1;
  endtask

  task automatic load_coefs(input int unsigned count, input bit full_range);
    int unsigned limit;
    limit = 131072 / (cur_mask * cur_mask);
    for (int unsigned i = 0; i < count; i++)
      send_beat(REQ_COEF, i, full_range ? $urandom_range(0, 65536) : $urandom_range(0, limit), 0);
  endtask

  function automatic int unsigned draw_pixel();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic run_frame(input int unsigned w, input int unsigned h);
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    eh = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
    for (int unsigned i = 0; i < ew * eh; i++) begin
      case ($urandom_range(0, 29))
        0: send_beat(REQ_FLUSH, 0, 0, 0);
        1: send_beat(REQ_RSVD, $urandom, $urandom, $urandom);
        2: send_beat(REQ_COEF, $urandom_range(0, cur_mask * cur_mask - 1),
                     $urandom_range(0, 65536 / (cur_mask * cur_mask)), 0);
        default: ;
      endcase
      send_beat(REQ_PIXEL, $urandom, $urandom, draw_pixel());
      pixels_sent++;
    end
    do begin
      if ($urandom_range(0, 4) == 0) begin
        in_bus.valid <= 0;
        @(posedge clk);
        if (frame_open) send_beat(REQ_PIXEL, 0, 0, draw_pixel());
      end
      send_beat(REQ_FLUSH, $urandom, $urandom, $urandom);
    end while (frame_open);
  endtask

  initial begin
    int unsigned w, h, m;
    rst_n <= 0;
    cfg_we <= 0;
    cfg_index <= CFG_WIDTH;
    cfg_data <= '0;
    in_bus.valid <= 0;
    in_bus.req_type <= REQ_COEF;
    in_bus.coef_index <= '0;
    in_bus.coef_value <= '0;
    in_bus.pixel <= '0;
    no_idle = 0;
    pixels_sent = 0;
    cur_mask = 3;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_frame(5, 4, 3);
    load_coefs(361, 1);
    send_beat(REQ_COEF, 0, 65536, 0);
    send_beat(REQ_COEF, 361, 0, 0);
    send_beat(REQ_COEF, 511, 131071, 0);
    send_beat(REQ_RSVD, 511, 131071, 65535);
    send_beat(REQ_FLUSH, 0, 0, 0);
    run_frame(5, 4);
    set_frame(1, 1, 1);
    run_frame(1, 1);
    set_frame(0, 0, 0);
    run_frame(0, 0);
    set_frame(3, 24, 3);
    load_coefs(9, 0);
    run_frame(3, 24);
    set_frame(6, 5, 4);
    run_frame(6, 5);
    set_frame(9, 7, 31);
    run_frame(9, 7);

    while (pixels_sent < 300) begin
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 12);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
      no_idle = ($urandom_range(0, 3) == 0);
      set_frame(w, h, m);
      if ($urandom_range(0, 1) == 0) load_coefs(cur_mask * cur_mask, $urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 2)) run_frame(w, h);
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
